[hw/rtl/fixed_width_decimal_formatter_top_macros.svh]
// Assertion macros for the fixed-width decimal formatter.
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_TOP_MACROS_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FWDF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FWDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fwdf_pkg.sv]
// Shared constants and types for the fixed-width decimal formatter.
package fwdf_pkg;

    localparam int MAX_WIDTH  = 16;
    localparam int BIN_W      = 32;
    localparam int WIDTH_W    = 5;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int STAGE_BITS = 8;
    localparam int NUM_STAGES = BIN_W / STAGE_BITS;
    localparam int CHAR_W     = 8;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

    // Item moving through the binary-to-BCD pipeline
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [BIN_W-1:0]   bin;
        logic [WIDTH_W-1:0] width;
    } dd_item_t;

    // One formatted character result
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              is_empty;
    } char_out_t;

endpackage

[hw/rtl/fwdf_dd_stage.sv]
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
module fwdf_dd_stage
    import fwdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dd_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output dd_item_t out_item
);

    logic     valid_reg;
    logic     valid_next;
    dd_item_t item_reg;
    dd_item_t item_next;

    // STAGE_BITS shift-add-3 steps, consuming the top bits of bin
    always_comb
    begin
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        bcd = in_item.bcd;
        bin = in_item.bin;
        for (int s = 0; s < STAGE_BITS; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd[4*d +: 4] >= 4'd5)
                begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
        end
        item_next.bcd   = bcd;
        item_next.bin   = bin;
        item_next.width = in_item.width;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hw/rtl/fwdf_serializer.sv]
// Emits the BCD digits of one item as a fixed-width ASCII field, one per cycle while the output is free.
module fwdf_serializer
    import fwdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dd_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output char_out_t out_char
);

    logic               busy_reg;
    logic               busy_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [WIDTH_W-1:0] pos_reg;
    logic [WIDTH_W-1:0] pos_next;
    logic               empty_reg;
    logic               ovalid_reg;
    logic               ovalid_next;
    char_out_t          ochar_reg;
    char_out_t          ochar_next;

    logic       out_free;
    logic       emit;
    logic       last_char;
    logic       accept;
    logic [3:0] digit;

    assign out_free  = !ovalid_reg || out_ready;
    assign emit      = busy_reg && out_free;
    assign last_char = (pos_reg == '0);
    assign in_ready  = !busy_reg || (emit && last_char);
    assign accept    = in_valid && in_ready;

    // Digit of weight 10^pos; weights above the top digit read as zero
    always_comb
    begin
        digit = 4'd0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (pos_reg == WIDTH_W'(i))
            begin
                digit = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pos_next  = (in_item.width == '0) ? '0 : in_item.width - 1'b1;
        end
        else if (emit)
        begin
            if (last_char)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        if (emit)
        begin
            ovalid_next          = 1'b1;
            ochar_next.char_code = empty_reg ? '0 : ASCII_ZERO + CHAR_W'(digit);
            ochar_next.is_last   = last_char;
            ochar_next.is_empty  = empty_reg;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        ochar_reg <= ochar_next;
        if (accept)
        begin
            bcd_reg   <= in_item.bcd;
            empty_reg <= (in_item.width == '0);
        end
    end

    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;

endmodule

[hw/rtl/fixed_width_decimal_formatter_top.sv]
// Top level of the fixed-width decimal formatter.
//
// Usage:
//   Input channel (s_*): one transfer carries a 32-bit unsigned value and a
//   5-bit field width. Widths above MAX_WIDTH saturate to MAX_WIDTH.
//   Output channel (m_*): one transfer per ASCII character, most significant
//   first, left-padded with '0'; when the width is below the digit count only
//   the low-order digits that fit appear. m_tlast marks the last character.
//   A zero width gives a single transfer with m_tdata 0, m_tlast 1, m_tuser 1.
// Path: an item passes through 4 conversion stages, loaded on its input
//   transfer and handed on from stage to stage, is then loaded into the
//   serializer, and its characters leave through one output register.
// Throughput: set by the serializer, which emits one character per cycle
//   while m_tready does not hold the output; a new item is loaded in the same cycle the
//   previous item's last character is emitted, so fields run back to back.
//   The conversion stages take a new item every cycle unless stalled.
// Reset: rst_n (asynchronous, active low) empties all stages and the output
//   register; items in flight are dropped.
// Stall: while m_tready is low the output register holds, the serializer and
//   the stages fill up, and s_tready drops once every stage holds an item.
//   Nothing is lost or repeated.
`include "fixed_width_decimal_formatter_top_macros.svh"

module fixed_width_decimal_formatter_top
    import fwdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [36:32] field_width, [39:37] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast,   // is_last
    output logic        m_tuser    // [0] is_empty
);

    logic [BIN_W-1:0]   value;
    logic [WIDTH_W-1:0] field_width;
    logic [WIDTH_W-1:0] width_sat;

    // Stage chain: index 0 is the input side, NUM_STAGES feeds the serializer
    logic     st_valid [NUM_STAGES+1];
    logic     st_ready [NUM_STAGES+1];
    dd_item_t st_item  [NUM_STAGES+1];

    char_out_t out_char;

    assign value       = s_tdata[BIN_W-1:0];
    assign field_width = s_tdata[BIN_W +: WIDTH_W];

    // Width saturation happens once, on entry
    assign width_sat = (int'(field_width) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : field_width;

    assign st_valid[0]      = s_tvalid;
    assign s_tready         = st_ready[0];
    assign st_item[0].bcd   = '0;
    assign st_item[0].bin   = value;
    assign st_item[0].width = width_sat;

    // Each stage converts STAGE_BITS bits of the binary value
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        fwdf_dd_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_item   (st_item[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_item  (st_item[g+1])
        );
    end

    fwdf_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[NUM_STAGES]),
        .in_ready  (st_ready[NUM_STAGES]),
        .in_item   (st_item[NUM_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char)
    );

    assign m_tdata = out_char.char_code;
    assign m_tlast = out_char.is_last;
    assign m_tuser = out_char.is_empty;

    // An empty field is a single closing transfer with a zero code
    `FWDF_ASSERT_IMP(a_empty_shape, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'h00), "empty result malformed")

    // Every real character is an ASCII decimal digit
    `FWDF_ASSERT_IMP(a_char_digit, m_tvalid && !m_tuser, (m_tdata >= 8'h30) && (m_tdata <= 8'h39), "character is not a decimal digit")

    // After an empty field's transfer, the next character cannot be flagged non-last empty
    `FWDF_ASSERT_NEXT(a_empty_after, m_tvalid && m_tready && m_tuser, !m_tvalid || m_tlast || !m_tuser, "bad result after empty field")

endmodule

[tb/fixed_width_decimal_formatter_top_test.sv]
// Self-checking testbench for the fixed-width decimal formatter top level.
module fixed_width_decimal_formatter_top_test
    import fwdf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing. The worst legal run is about 500 items x 16 characters with the
    // receiver ready one cycle in four, plus sender gaps and the long hold. The
    // limit gives that several times over.
    localparam int RANDOM_ITEMS     = 480;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 24;     // longer than the first-character latency
    localparam int CYCLE_LIMIT      = 250000;
    localparam int DIRECTED_ROWS    = 20;

    // One input item. Rows marked typed carry their expected text literally;
    // an empty text on a typed row means the single empty-field transfer.
    typedef struct {
        logic [BIN_W-1:0]   value;
        logic [WIDTH_W-1:0] width;
        bit                 typed;
        string              txt;
    } fmt_item_t;

    // Receiver stall patterns, each held for a random stretch of cycles.
    typedef enum int {
        RX_FREE,      // always ready
        RX_COIN,      // ready half the time
        RX_SPARSE,    // ready one cycle in four, at random
        RX_CADENCE    // fixed repeating on/off rhythm
    } rx_mode_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata  = '0;  // [31:0] value, [36:32] field_width, [39:37] zero
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;        // [7:0] char_code
    logic                m_tlast;        // is_last
    logic                m_tuser;        // [0] is_empty

    // Characters still owed by the block, oldest first.
    char_out_t           pending_chars[$];

    int                  error_count     = 0;
    int                  chars_checked   = 0;
    int                  items_sent      = 0;
    int                  empty_fields    = 0;
    int                  clipped_widths  = 0;
    int                  input_stalls    = 0;
    int                  cycle_count     = 0;
    bit                  long_hold_req   = 1'b0;

    // Power-of-ten boundaries feed the random value mix.
    logic [BIN_W-1:0]    decade[NUM_DIGITS];

    // Directed rows: extremes, zero width, saturation, truncation, carry edges.
    fmt_item_t directed_rows[DIRECTED_ROWS] = '{
        '{32'd0,          5'd0,  1'b1, ""},
        '{32'hFFFF_FFFF,  5'd0,  1'b1, ""},
        '{32'd0,          5'd1,  1'b1, "0"},
        '{32'd0,          5'd16, 1'b1, "0000000000000000"},
        '{32'hFFFF_FFFF,  5'd10, 1'b1, "4294967295"},
        '{32'hFFFF_FFFF,  5'd16, 1'b1, "0000004294967295"},
        '{32'hFFFF_FFFF,  5'd31, 1'b1, "0000004294967295"},
        '{32'd1000000000, 5'd17, 1'b1, "0000001000000000"},
        '{32'd123456789,  5'd3,  1'b1, "789"},
        '{32'd999999999,  5'd9,  1'b1, "999999999"},
        '{32'd10,         5'd1,  1'b1, "0"},
        '{32'hFFFF_FFFF,  5'd1,  1'b1, "5"},
        '{32'd1000000000, 5'd10, 1'b1, "1000000000"},
        '{32'd12345,      5'd5,  1'b0, ""},
        '{32'd12345,      5'd8,  1'b0, ""},
        '{32'h8000_0000,  5'd11, 1'b0, ""},
        '{32'd7,          5'd15, 1'b0, ""},
        '{32'hAAAA_AAAA,  5'd2,  1'b0, ""},
        '{32'h5555_5555,  5'd24, 1'b0, ""},
        '{32'd99,         5'd12, 1'b0, ""}
    };

    fixed_width_decimal_formatter_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor: character k of a w-wide field is the decimal digit of weight
    // 10^(w-1-k); weights past 10^9 read as '0'. Width saturates at MAX_WIDTH,
    // and a zero width owes one empty-flagged transfer.
    task automatic queue_decimal_field(input logic [BIN_W-1:0] value,
                                       input logic [WIDTH_W-1:0] width);
        logic [BIN_W-1:0] rest;
        logic [3:0]       digit[NUM_DIGITS];
        char_out_t        c;
        int               eff;
        int               pos;
        eff  = (int'(width) > MAX_WIDTH) ? MAX_WIDTH : int'(width);
        rest = value;
        for (int p = 0; p < NUM_DIGITS; p++)
        begin
            digit[p] = 4'(rest % 10);
            rest     = rest / 10;
        end
        if (eff == 0)
        begin
            c.char_code = '0;
            c.is_last   = 1'b1;
            c.is_empty  = 1'b1;
            pending_chars.push_back(c);
        end
        else
        begin
            for (int k = 0; k < eff; k++)
            begin
                pos         = eff - 1 - k;
                c.char_code = ASCII_ZERO + ((pos < NUM_DIGITS) ? CHAR_W'(digit[pos]) : '0);
                c.is_last   = (k == eff - 1);
                c.is_empty  = 1'b0;
                pending_chars.push_back(c);
            end
        end
    endtask

    // Expected characters for an accepted item: literal text on typed rows,
    // the predictor everywhere else.
    task automatic owe_field(input fmt_item_t it);
        char_out_t c;
        if (!it.typed)
            queue_decimal_field(it.value, it.width);
        else if (it.txt.len() == 0)
        begin
            c.char_code = '0;
            c.is_last   = 1'b1;
            c.is_empty  = 1'b1;
            pending_chars.push_back(c);
        end
        else
        begin
            for (int i = 0; i < it.txt.len(); i++)
            begin
                c.char_code = it.txt[i];
                c.is_last   = (i == it.txt.len() - 1);
                c.is_empty  = 1'b0;
                pending_chars.push_back(c);
            end
        end
        items_sent++;
        if (it.width == 0)
            empty_fields++;
        if (int'(it.width) > MAX_WIDTH)
            clipped_widths++;
    endtask

    // Offer one item and hold it until the transfer happens. tvalid is left high
    // so a following item goes out back to back without a dip.
    task automatic send_item(input fmt_item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.width, it.value};
        do
        begin
            @(posedge clk);
            if (!s_tready)
                input_stalls++;
        end
        while (!s_tready);
        owe_field(it);
    endtask

    // Random item: a value mix biased toward digit-count boundaries and mostly
    // in-range widths, with zero and over-range widths sprinkled in.
    function automatic fmt_item_t random_item();
        fmt_item_t it;
        int        sel;
        it.typed = 1'b0;
        it.txt   = "";
        sel      = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: it.value = $urandom;
            4, 5:       it.value = $urandom_range(0, 999);
            6:          it.value = decade[$urandom_range(0, NUM_DIGITS - 1)]
                                   - BIN_W'($urandom_range(0, 1));
            7:          it.value = 32'hFFFF_FFFF - BIN_W'($urandom_range(0, 5));
            8:          it.value = $urandom >> $urandom_range(0, 31);
            default:    it.value = $urandom_range(0, 9);
        endcase
        sel = $urandom_range(0, 19);
        if (sel == 0)
            it.width = '0;
        else if (sel <= 2)
            it.width = WIDTH_W'($urandom_range(MAX_WIDTH + 1, 31));
        else if (sel <= 5)
            it.width = WIDTH_W'(MAX_WIDTH);
        else
            it.width = WIDTH_W'($urandom_range(1, MAX_WIDTH - 1));
        return it;
    endfunction

    // Receiver: switches between stall patterns on its own schedule, and on
    // request from the sender refuses everything for a long stretch so the
    // path fills and s_tready drops.
    initial
    begin : receiver
        rx_mode_t mode;
        int       phase_left;
        int       tick;
        int       hold_left;
        mode       = RX_FREE;
        phase_left = 0;
        tick       = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (phase_left == 0)
            begin
                mode       = rx_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    // Output checker: every character transfer is matched, field by field,
    // against the oldest owed character.
    always @(posedge clk)
    begin
        char_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer: char_code %h last %b empty %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_tdata !== want.char_code)
                begin
                    error_count++;
                    $display("%0t: char_code expected %h actual %h",
                             $time, want.char_code, m_tdata);
                end
                if (m_tlast !== want.is_last)
                begin
                    error_count++;
                    $display("%0t: is_last expected %b actual %b",
                             $time, want.is_last, m_tlast);
                end
                if (m_tuser !== want.is_empty)
                begin
                    error_count++;
                    $display("%0t: is_empty expected %b actual %b",
                             $time, want.is_empty, m_tuser);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d characters outstanding",
                 $time, pending_chars.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus: reset, directed table, then bursty random traffic.
    initial
    begin : stimulus
        fmt_item_t it;
        int        burst_left;
        int        gap;
        int        idle;
        decade[0] = 32'd1;
        for (int p = 1; p < NUM_DIGITS; p++)
            decade[p] = decade[p - 1] * 10;
        burst_left = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows go out back to back.
        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                // Long receiver hold while the sender keeps offering: the
                // conversion stages fill and the input must stall.
                long_hold_req = 1'b1;
                burst_left    = 60;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                // Full drain before carrying on.
                s_tvalid <= 1'b0;
                while (pending_chars.size() != 0)
                    @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else if (n >= RANDOM_ITEMS - 60)
                burst_left = 1;             // closing stretch without sender gaps
            else if (burst_left == 0)
            begin
                gap        = $urandom_range(0, 12);
                burst_left = $urandom_range(1, 20);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= {$urandom, 8'($urandom)};  // noise while idle
                    for (idle = 0; idle < gap; idle++)
                        @(posedge clk);
                end
            end
            it = random_item();
            send_item(it);
            burst_left--;
        end
        s_tvalid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d zero-width, %0d over-range widths); %0d characters checked.",
                 items_sent, empty_fields, clipped_widths, chars_checked);
        $display("Input was held off on %0d edges; %0d mismatches seen.",
                 input_stalls, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
